FILE: rtl/fagr_pkg.sv
// ----------------------------------------------------------------------------
// fagr_pkg
// Shared types and codes for the fraction ALU with GCD reduction.
// ----------------------------------------------------------------------------
package fagr_pkg;

    localparam int unsigned RES_WIDTH = 33;

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_RED = 3'd4
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_GCD_START,
        ST_GCD_WAIT,
        ST_NUM_START,
        ST_NUM_WAIT,
        ST_DEN_START,
        ST_DEN_WAIT,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/fraction_alu_with_gcd_reduce_core.sv
// ----------------------------------------------------------------------------
// fraction_alu_with_gcd_reduce_core
// Fraction add, subtract, multiply, divide and GCD reduce.
// ----------------------------------------------------------------------------
// One item at a time. Add, subtract, multiply and divide run up to three
// products through one shared multiplier, one product a cycle. Reduce runs
// Euclid's method through one serial divider of OPERAND_WIDTH+1 bits, then
// two more divisions for the results. The result waits in an output
// register; s_ready is high only while the block is idle and no result is
// waiting.
module fraction_alu_with_gcd_reduce_core #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic signed [15:0] s_a_num,
    input  logic signed [15:0] s_a_den,
    input  logic signed [15:0] s_b_num,
    input  logic signed [15:0] s_b_den,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [32:0] m_res_num,
    output logic signed [32:0] m_res_den,
    output logic        m_error
);

    localparam int W = OPERAND_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * W;
    localparam int RW = fagr_pkg::RES_WIDTH;

    fagr_pkg::state_t state_reg, state_next;

    logic [2:0]     mode_reg;
    logic [W-1:0]   an_reg, ad_reg, bn_reg, bd_reg;
    logic [DW-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [PW:0] acc_reg, acc_next;
    logic signed [PW:0] den_reg, den_next;
    logic [RW-1:0]  out_num_reg, out_num_next;
    logic [RW-1:0]  out_den_reg, out_den_next;
    logic           out_err_reg, out_err_next;
    logic           mval_reg, mval_next;

    logic signed [W-1:0]  mul_a, mul_b;
    logic signed [PW-1:0] prod;

    logic          div_start;
    logic [DW-1:0] div_dvd, div_dvs;
    logic          div_done;
    logic [DW-1:0] div_q, div_r;

    logic [31:0]   in_an, in_ad, in_bn, in_bd;

    logic accept;
    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == fagr_pkg::ST_IDLE) && !mval_reg;

    assign in_an = {16'b0, s_a_num};
    assign in_ad = {16'b0, s_a_den};
    assign in_bn = {16'b0, s_b_num};
    assign in_bd = {16'b0, s_b_den};

    assign prod = mul_a * mul_b;

    fagr_divider #(.W(DW)) u_div (
        .aclk(aclk),
        .aresetn(aresetn),
        .start(div_start),
        .dividend(div_dvd),
        .divisor(div_dvs),
        .done(div_done),
        .quotient(div_q),
        .remainder(div_r)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fagr_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_mode == fagr_pkg::MODE_RED) begin
                        state_next = (in_ad[W-1:0] == '0) ? fagr_pkg::ST_DONE
                                                          : fagr_pkg::ST_GCD_START;
                    end else if (s_mode <= fagr_pkg::MODE_DIV) begin
                        state_next = fagr_pkg::ST_MUL1;
                    end else begin
                        state_next = fagr_pkg::ST_DONE;
                    end
                end
            end
            fagr_pkg::ST_MUL1: state_next = fagr_pkg::ST_MUL2;
            fagr_pkg::ST_MUL2: state_next = fagr_pkg::ST_MUL3;
            fagr_pkg::ST_MUL3: state_next = fagr_pkg::ST_MUL4;
            fagr_pkg::ST_MUL4: state_next = fagr_pkg::ST_DONE;
            fagr_pkg::ST_GCD_START: state_next = fagr_pkg::ST_GCD_WAIT;
            fagr_pkg::ST_GCD_WAIT: begin
                if (div_done) begin
                    state_next = (div_r == '0) ? fagr_pkg::ST_NUM_START
                                               : fagr_pkg::ST_GCD_START;
                end
            end
            fagr_pkg::ST_NUM_START: state_next = fagr_pkg::ST_NUM_WAIT;
            fagr_pkg::ST_NUM_WAIT: begin
                if (div_done) begin
                    state_next = fagr_pkg::ST_DEN_START;
                end
            end
            fagr_pkg::ST_DEN_START: state_next = fagr_pkg::ST_DEN_WAIT;
            fagr_pkg::ST_DEN_WAIT: begin
                if (div_done) begin
                    state_next = fagr_pkg::ST_DONE;
                end
            end
            fagr_pkg::ST_DONE: state_next = fagr_pkg::ST_IDLE;
            default: state_next = fagr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        acc_next = acc_reg;
        den_next = den_reg;
        out_num_next = out_num_reg;
        out_den_next = out_den_reg;
        out_err_next = out_err_reg;
        mval_next = mval_reg;
        mul_a = '0;
        mul_b = '0;
        div_start = 1'b0;
        div_dvd = x_reg;
        div_dvs = y_reg;
        if (mval_reg && m_ready) begin
            mval_next = 1'b0;
        end
        case (state_reg)
            fagr_pkg::ST_IDLE: begin
                acc_next = '0;
                den_next = '0;
                x_next = {in_an[W-1], in_an[W-1:0]};
                y_next = {in_ad[W-1], in_ad[W-1:0]};
            end
            fagr_pkg::ST_MUL1: begin
                mul_a = an_reg;
                mul_b = (mode_reg == fagr_pkg::MODE_MUL) ? bn_reg : bd_reg;
                acc_next = (PW+1)'(prod);
            end
            fagr_pkg::ST_MUL2: begin
                mul_a = ad_reg;
                mul_b = bn_reg;
                if (mode_reg == fagr_pkg::MODE_ADD) begin
                    acc_next = acc_reg + (PW+1)'(prod);
                end else if (mode_reg == fagr_pkg::MODE_SUB) begin
                    acc_next = acc_reg - (PW+1)'(prod);
                end else if (mode_reg == fagr_pkg::MODE_DIV) begin
                    den_next = (PW+1)'(prod);
                end
            end
            fagr_pkg::ST_MUL3: begin
                mul_a = ad_reg;
                mul_b = bd_reg;
                if (mode_reg != fagr_pkg::MODE_DIV) begin
                    den_next = (PW+1)'(prod);
                end
            end
            fagr_pkg::ST_MUL4: begin
                out_num_next = RW'(PW+1 > RW ? acc_reg : $signed(acc_reg));
                out_den_next = RW'(den_reg);
            end
            fagr_pkg::ST_GCD_START: div_start = 1'b1;
            fagr_pkg::ST_GCD_WAIT: begin
                if (div_done && div_r != '0) begin
                    x_next = y_reg;
                    y_next = div_r;
                end
            end
            fagr_pkg::ST_NUM_START: begin
                div_start = 1'b1;
                div_dvd = {an_reg[W-1], an_reg};
            end
            fagr_pkg::ST_NUM_WAIT: begin
                if (div_done) begin
                    out_num_next = RW'($signed(div_q));
                end
            end
            fagr_pkg::ST_DEN_START: begin
                div_start = 1'b1;
                div_dvd = {ad_reg[W-1], ad_reg};
            end
            fagr_pkg::ST_DEN_WAIT: begin
                if (div_done) begin
                    out_den_next = RW'($signed(div_q));
                end
            end
            fagr_pkg::ST_DONE: begin
                mval_next = 1'b1;
                if (mode_reg > fagr_pkg::MODE_RED ||
                    (mode_reg == fagr_pkg::MODE_RED && ad_reg == '0)) begin
                    out_num_next = '0;
                    out_den_next = '0;
                end
                out_err_next = (mode_reg == fagr_pkg::MODE_RED) && (ad_reg == '0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fagr_pkg::ST_IDLE;
            mval_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mval_reg <= mval_next;
        end
        if (accept) begin
            mode_reg <= s_mode;
            an_reg <= in_an[W-1:0];
            ad_reg <= in_ad[W-1:0];
            bn_reg <= in_bn[W-1:0];
            bd_reg <= in_bd[W-1:0];
        end
        x_reg <= x_next;
        y_reg <= y_next;
        acc_reg <= acc_next;
        den_reg <= den_next;
        out_num_reg <= out_num_next;
        out_den_reg <= out_den_next;
        out_err_reg <= out_err_next;
    end

    assign m_valid = mval_reg;
    assign m_res_num = out_num_reg;
    assign m_res_den = out_den_reg;
    assign m_error = out_err_reg;

endmodule

FILE: rtl/fagr_divider.sv
// ----------------------------------------------------------------------------
// fagr_divider
// Serial signed divider, one quotient bit per cycle, truncating quotient
// and remainder with the sign of the dividend.
// ----------------------------------------------------------------------------
module fagr_divider #(
    parameter int W = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);

    logic         busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0] q_reg, q_next;
    logic [W:0]   r_reg, r_next;
    logic [W-1:0] d_reg, d_next;
    logic         qneg_reg, qneg_next;
    logic         rneg_reg, rneg_next;
    logic         done_reg, done_next;
    logic [W:0]   shifted;
    logic [W:0]   diff;
    logic [W-1:0] abs_a;
    logic [W-1:0] abs_b;

    assign abs_a = dividend[W-1] ? (~dividend + 1'b1) : dividend;
    assign abs_b = divisor[W-1] ? (~divisor + 1'b1) : divisor;
    assign shifted = {r_reg[W-1:0], q_reg[W-1]};
    assign diff = shifted - {1'b0, d_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next = CW'(W);
            q_next = abs_a;
            r_next = '0;
            d_next = abs_b;
            qneg_next = dividend[W-1] ^ divisor[W-1];
            rneg_next = dividend[W-1];
        end else if (busy_reg) begin
            if (diff[W]) begin
                r_next = shifted;
                q_next = {q_reg[W-2:0], 1'b0};
            end else begin
                r_next = diff;
                q_next = {q_reg[W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign done = done_reg;
    assign quotient = qneg_reg ? (~q_reg + 1'b1) : q_reg;
    assign remainder = rneg_reg ? (~r_reg[W-1:0] + 1'b1) : r_reg[W-1:0];

endmodule

FILE: rtl/fagr_checker.sv
// ----------------------------------------------------------------------------
// fagr_checker
// Port-level checks for the fraction ALU core.
// ----------------------------------------------------------------------------
module fagr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [32:0] m_res_num,
    input logic [32:0] m_res_den,
    input logic        m_error
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res_num) && $stable(m_res_den))
        else $error("result item changed while stalled");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while busy");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> m_res_num == '0 && m_res_den == '0)
        else $error("error item not 0/0");

endmodule

bind fraction_alu_with_gcd_reduce_core fagr_checker u_fagr_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_res_num(m_res_num),
    .m_res_den(m_res_den),
    .m_error(m_error)
);
